>>> rtl/core/m3i_pkg.sv
// Shared types and constants for the 3x3 matrix inverse datapath.
// Used by the stream interface, the cofactor unit, the divider lanes and the top level.
// No dependencies.
package m3i_pkg;

    localparam int NumElem = 9;
    localparam int ElemW   = 32;
    localparam int ProdW   = 2 * ElemW;
    localparam int CofW    = ProdW + 1;
    localparam int PartW   = CofW;
    localparam int DetW    = ProdW + ElemW + 3;
    localparam int MagW    = ProdW;
    localparam int MagdW   = DetW - 3;
    localparam int QW      = 32;
    localparam int NumW    = MagW + QW + 2;
    localparam int DenW    = MagdW + 1;
    localparam int HiW     = NumW - QW;
    localparam int CofLat  = 5;
    localparam int LaneLat = QW + 3;
    localparam int PipeLat = CofLat + LaneLat;

    localparam logic [ElemW-1:0] SatPos = {1'b0, {(ElemW-1){1'b1}}};
    localparam logic [ElemW-1:0] SatNeg = {1'b1, {(ElemW-1){1'b0}}};

    // Each cofactor is P - Q with P = m[pa]*m[pb] and Q = m[qa]*m[qb];
    // the sign of the checkerboard is folded into the operand order.
    localparam logic [3:0] PA [NumElem] = '{4'd4, 4'd5, 4'd3, 4'd2, 4'd0, 4'd1, 4'd1, 4'd2, 4'd0};
    localparam logic [3:0] PB [NumElem] = '{4'd8, 4'd6, 4'd7, 4'd7, 4'd8, 4'd6, 4'd5, 4'd3, 4'd4};
    localparam logic [3:0] QA [NumElem] = '{4'd5, 4'd3, 4'd4, 4'd1, 4'd2, 4'd0, 4'd2, 4'd0, 4'd1};
    localparam logic [3:0] QB [NumElem] = '{4'd7, 4'd8, 4'd6, 4'd8, 4'd6, 4'd7, 4'd4, 4'd5, 4'd3};

    // Adjugate element j is cofactor ADJ[j] (transpose).
    localparam logic [3:0] ADJ [NumElem] = '{4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8};

    typedef logic signed [ElemW-1:0] elem_t;
    typedef logic signed [ProdW-1:0] prod_t;
    typedef logic signed [CofW-1:0]  cof_t;
    typedef logic signed [PartW-1:0] part_t;
    typedef logic signed [DetW-1:0]  det_t;
    typedef logic [MagW-1:0]         mag_t;
    typedef logic [MagdW-1:0]        magd_t;

    typedef struct packed {
        logic signed [ElemW-1:0] elem_0;
        logic signed [ElemW-1:0] elem_1;
        logic signed [ElemW-1:0] elem_2;
        logic signed [ElemW-1:0] elem_3;
        logic signed [ElemW-1:0] elem_4;
        logic signed [ElemW-1:0] elem_5;
        logic signed [ElemW-1:0] elem_6;
        logic signed [ElemW-1:0] elem_7;
        logic signed [ElemW-1:0] elem_8;
    } mat_t;

    typedef struct packed {
        logic signed [ElemW-1:0] inv_0;
        logic signed [ElemW-1:0] inv_1;
        logic signed [ElemW-1:0] inv_2;
        logic signed [ElemW-1:0] inv_3;
        logic signed [ElemW-1:0] inv_4;
        logic signed [ElemW-1:0] inv_5;
        logic signed [ElemW-1:0] inv_6;
        logic signed [ElemW-1:0] inv_7;
        logic signed [ElemW-1:0] inv_8;
        logic                    singular;
        logic                    overflow;
    } res_t;

    // Determinant information handed from the cofactor unit to the lanes.
    typedef struct packed {
        logic [NumElem-1:0] neg;
        magd_t              magd;
        logic               singular;
    } det_info_t;

endpackage

>>> rtl/core/m3i_stream_if.sv
// Valid/ready stream channel used for the request and result ports.
// Depends on m3i_pkg for the default payload type.
interface m3i_stream_if #(parameter type payload_t = m3i_pkg::mat_t);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

>>> rtl/core/m3i_cofactor.sv
// Cofactor and determinant pipeline: 2x2 minors, first-row expansion, magnitudes.
// Depends on m3i_pkg. Five register stages, all advanced by en.
module m3i_cofactor (
    input  logic                  clk,
    input  logic                  en,
    input  m3i_pkg::elem_t        m [m3i_pkg::NumElem],
    output m3i_pkg::mag_t         ma [m3i_pkg::NumElem],
    output m3i_pkg::det_info_t    info
);

    m3i_pkg::prod_t  pa_reg [m3i_pkg::NumElem];
    m3i_pkg::prod_t  qa_reg [m3i_pkg::NumElem];
    m3i_pkg::elem_t  m1_reg [3];
    m3i_pkg::elem_t  m2_reg [3];
    m3i_pkg::cof_t   c2_reg [m3i_pkg::NumElem];
    m3i_pkg::cof_t   c3_reg [m3i_pkg::NumElem];
    m3i_pkg::cof_t   c4_reg [m3i_pkg::NumElem];
    m3i_pkg::part_t  plo_reg [3];
    m3i_pkg::part_t  phi_reg [3];
    m3i_pkg::det_t   det_reg;
    m3i_pkg::det_t   det_next;
    m3i_pkg::det_t   det_abs;
    m3i_pkg::cof_t   adj_abs [m3i_pkg::NumElem];
    m3i_pkg::mag_t   ma_reg [m3i_pkg::NumElem];
    m3i_pkg::det_info_t info_reg;

    // Stage 1: the eighteen element products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < m3i_pkg::NumElem; k++)
            begin
                pa_reg[k] <= m3i_pkg::prod_t'(m[m3i_pkg::PA[k]])
                           * m3i_pkg::prod_t'(m[m3i_pkg::PB[k]]);
                qa_reg[k] <= m3i_pkg::prod_t'(m[m3i_pkg::QA[k]])
                           * m3i_pkg::prod_t'(m[m3i_pkg::QB[k]]);
            end
            for (int i = 0; i < 3; i++)
            begin
                m1_reg[i] <= m[i];
            end
        end
    end

    // Stage 2: signed cofactors.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < m3i_pkg::NumElem; k++)
            begin
                c2_reg[k] <= m3i_pkg::cof_t'(pa_reg[k]) - m3i_pkg::cof_t'(qa_reg[k]);
            end
            m2_reg <= m1_reg;
        end
    end

    // Stage 3: each 32 x 65 determinant term as two 32 x 33 partial products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                plo_reg[i] <= m3i_pkg::part_t'(m2_reg[i])
                            * m3i_pkg::part_t'($signed({1'b0, c2_reg[i][m3i_pkg::ElemW-1:0]}));
                phi_reg[i] <= m3i_pkg::part_t'(m2_reg[i])
                            * m3i_pkg::part_t'($signed(c2_reg[i][m3i_pkg::CofW-1:m3i_pkg::ElemW]));
            end
            c3_reg <= c2_reg;
        end
    end

    always_comb
    begin
        det_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            det_next = det_next + (m3i_pkg::det_t'(phi_reg[i]) <<< m3i_pkg::ElemW)
                     + m3i_pkg::det_t'(plo_reg[i]);
        end
    end

    // Stage 4: exact determinant.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg <= det_next;
            c4_reg  <= c3_reg;
        end
    end

    always_comb
    begin
        det_abs = det_reg[m3i_pkg::DetW-1] ? -det_reg : det_reg;
        for (int j = 0; j < m3i_pkg::NumElem; j++)
        begin
            adj_abs[j] = c4_reg[m3i_pkg::ADJ[j]][m3i_pkg::CofW-1]
                       ? -c4_reg[m3i_pkg::ADJ[j]] : c4_reg[m3i_pkg::ADJ[j]];
        end
    end

    // Stage 5: magnitudes and result signs of the adjugate and determinant.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < m3i_pkg::NumElem; j++)
            begin
                ma_reg[j]       <= adj_abs[j][m3i_pkg::MagW-1:0];
                info_reg.neg[j] <= c4_reg[m3i_pkg::ADJ[j]][m3i_pkg::CofW-1]
                                 ^ det_reg[m3i_pkg::DetW-1];
            end
            info_reg.magd     <= det_abs[m3i_pkg::MagdW-1:0];
            info_reg.singular <= (det_reg == '0);
        end
    end

    assign ma   = ma_reg;
    assign info = info_reg;

endmodule

>>> rtl/core/m3i_lane.sv
// One divider lane: rounds |adj| * 2^32 / |det| to nearest, restores sign, saturates.
// Depends on m3i_pkg. One quotient bit per bit stage, 35 register stages in all.
module m3i_lane (
    input  logic                  clk,
    input  logic                  en,
    input  m3i_pkg::mag_t         ma,
    input  m3i_pkg::magd_t        magd,
    input  logic                  neg,
    output m3i_pkg::elem_t        val,
    output logic                  sat
);

    localparam int QW = m3i_pkg::QW;

    logic [m3i_pkg::NumW-1:0] num_reg;
    logic [m3i_pkg::DenW-1:0] den1_reg;
    logic                     neg1_reg;
    logic [m3i_pkg::HiW-1:0]  hi;
    logic                     pre_ovf;

    logic [m3i_pkg::DenW-1:0] r_reg   [QW+1];
    logic [m3i_pkg::DenW-1:0] den_reg [QW+1];
    logic [QW-1:0]            lo_reg  [QW+1];
    logic [QW-1:0]            q_reg   [QW+1];
    logic                     neg_reg [QW+1];
    logic                     ovf_reg [QW+1];

    logic [QW-1:0]            limit;
    logic                     over;
    m3i_pkg::elem_t           val_reg;
    logic                     sat_reg;

    // Rounding term: (2*|adj|*2^32 + |det|) / (2*|det|).
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg  <= m3i_pkg::NumW'({ma, {(QW+1){1'b0}}}) + m3i_pkg::NumW'(magd);
            den1_reg <= {magd, 1'b0};
            neg1_reg <= neg;
        end
    end

    // A quotient of 2^32 or more saturates; the remainder is then cleared so
    // that the bit stages stay within range.
    assign hi      = num_reg[m3i_pkg::NumW-1:QW];
    assign pre_ovf = m3i_pkg::DenW'(hi) >= den1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]   <= pre_ovf ? '0 : m3i_pkg::DenW'(hi);
            den_reg[0] <= den1_reg;
            lo_reg[0]  <= num_reg[QW-1:0];
            q_reg[0]   <= '0;
            neg_reg[0] <= neg1_reg;
            ovf_reg[0] <= pre_ovf;
        end
    end

    for (genvar s = 0; s < QW; s++)
    begin : g_bit
        localparam int B = QW - 1 - s;
        logic [m3i_pkg::DenW:0]   trial;
        logic [m3i_pkg::DenW:0]   diff;
        logic                     ge;
        logic [m3i_pkg::DenW-1:0] r_next;
        logic [QW-1:0]            q_next;

        always_comb
        begin
            trial  = {r_reg[s], lo_reg[s][B]};
            diff   = trial - {1'b0, den_reg[s]};
            ge     = trial >= {1'b0, den_reg[s]};
            r_next = ge ? diff[m3i_pkg::DenW-1:0] : trial[m3i_pkg::DenW-1:0];
            q_next = q_reg[s];
            q_next[B] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[s+1]   <= r_next;
                den_reg[s+1] <= den_reg[s];
                lo_reg[s+1]  <= lo_reg[s];
                q_reg[s+1]   <= q_next;
                neg_reg[s+1] <= neg_reg[s];
                ovf_reg[s+1] <= ovf_reg[s];
            end
        end
    end

    assign limit = neg_reg[QW] ? m3i_pkg::SatNeg : m3i_pkg::SatPos;
    assign over  = ovf_reg[QW] || (q_reg[QW] > limit);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_reg <= over;
            if (over)
            begin
                val_reg <= limit;
            end
            else
            begin
                val_reg <= neg_reg[QW] ? -q_reg[QW] : q_reg[QW];
            end
        end
    end

    assign val = val_reg;
    assign sat = sat_reg;

endmodule

>>> rtl/core/matrix3_inverse.sv
// 3x3 matrix inverse by the adjugate method in signed Q16.16.
// Top level: cofactor unit, nine divider lanes, merge stage and output register.
// Depends on m3i_pkg, m3i_stream_if, m3i_cofactor and m3i_lane.
//
// Usage:
//   in_req carries one matrix per request, elements in row-major order.
//   out_res returns one result per request: the nine inverse elements plus
//   the singular and overflow flags. A singular matrix gives all-zero
//   elements with singular set.
//   From the accepting edge to out_res.valid a request passes the five
//   cofactor/determinant stages (the accepting edge loads the first),
//   then the 35 stages in each divider lane (one quotient bit per bit
//   stage) and the output register.
//   Throughput is one matrix per cycle unless stalled; the nine lanes divide the
//   adjugate elements side by side and the merge stage folds their flags.
//   When the receiver stalls, the result waits in the output register and the
//   pipeline keeps filling until a finished result reaches its last stage;
//   only then does in_req.ready drop.
//   Reset clears all valid flags; no request is in flight afterward.
module matrix3_inverse (
    input  logic clk,
    input  logic rst_n,
    m3i_stream_if.sink   in_req,
    m3i_stream_if.source out_res
);

    localparam int N = m3i_pkg::NumElem;

    m3i_pkg::elem_t     m [N];
    m3i_pkg::mag_t      ma [N];
    m3i_pkg::det_info_t info;
    m3i_pkg::elem_t     lane_val [N];
    logic [N-1:0]       lane_sat;

    logic [m3i_pkg::PipeLat-1:0] vld_reg;
    logic                        sing_reg [m3i_pkg::LaneLat];
    logic                        en;
    logic                        load;
    logic                        out_valid_reg;
    m3i_pkg::res_t               res_reg;
    m3i_pkg::res_t               res_next;
    logic                        last_vld;
    logic                        last_sing;

    assign m[0] = in_req.data.elem_0;
    assign m[1] = in_req.data.elem_1;
    assign m[2] = in_req.data.elem_2;
    assign m[3] = in_req.data.elem_3;
    assign m[4] = in_req.data.elem_4;
    assign m[5] = in_req.data.elem_5;
    assign m[6] = in_req.data.elem_6;
    assign m[7] = in_req.data.elem_7;
    assign m[8] = in_req.data.elem_8;

    assign last_vld  = vld_reg[m3i_pkg::PipeLat-1];
    assign last_sing = sing_reg[m3i_pkg::LaneLat-1];

    // The pipeline holds only while a finished result has nowhere to go.
    assign en   = !last_vld || !out_valid_reg || out_res.ready;
    assign load = last_vld && (!out_valid_reg || out_res.ready);

    assign in_req.ready = en;

    m3i_cofactor u_cof (
        .clk  (clk),
        .en   (en),
        .m    (m),
        .ma   (ma),
        .info (info)
    );

    for (genvar j = 0; j < N; j++)
    begin : g_lane
        m3i_lane u_lane (
            .clk  (clk),
            .en   (en),
            .ma   (ma[j]),
            .magd (info.magd),
            .neg  (info.neg[j]),
            .val  (lane_val[j]),
            .sat  (lane_sat[j])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[m3i_pkg::PipeLat-2:0], in_req.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sing_reg[0] <= info.singular;
            for (int k = 1; k < m3i_pkg::LaneLat; k++)
            begin
                sing_reg[k] <= sing_reg[k-1];
            end
        end
    end

    // Merge: a singular matrix zeroes every element and masks saturation.
    always_comb
    begin
        res_next.inv_0    = last_sing ? '0 : lane_val[0];
        res_next.inv_1    = last_sing ? '0 : lane_val[1];
        res_next.inv_2    = last_sing ? '0 : lane_val[2];
        res_next.inv_3    = last_sing ? '0 : lane_val[3];
        res_next.inv_4    = last_sing ? '0 : lane_val[4];
        res_next.inv_5    = last_sing ? '0 : lane_val[5];
        res_next.inv_6    = last_sing ? '0 : lane_val[6];
        res_next.inv_7    = last_sing ? '0 : lane_val[7];
        res_next.inv_8    = last_sing ? '0 : lane_val[8];
        res_next.singular = last_sing;
        res_next.overflow = !last_sing && (|lane_sat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    assign out_res.valid = out_valid_reg;
    assign out_res.data  = res_reg;

endmodule

>>> rtl/core/m3i_checker.sv
// Port-level checks on the result channel of matrix3_inverse, bound to the top level.
// Depends on m3i_pkg and m3i_stream_if.
module m3i_checker (
    input logic clk,
    input logic rst_n,
    m3i_stream_if.source res
);

    logic any_sat;
    logic all_zero;

    assign any_sat =
        res.data.inv_0 == m3i_pkg::SatPos || res.data.inv_0 == m3i_pkg::SatNeg ||
        res.data.inv_1 == m3i_pkg::SatPos || res.data.inv_1 == m3i_pkg::SatNeg ||
        res.data.inv_2 == m3i_pkg::SatPos || res.data.inv_2 == m3i_pkg::SatNeg ||
        res.data.inv_3 == m3i_pkg::SatPos || res.data.inv_3 == m3i_pkg::SatNeg ||
        res.data.inv_4 == m3i_pkg::SatPos || res.data.inv_4 == m3i_pkg::SatNeg ||
        res.data.inv_5 == m3i_pkg::SatPos || res.data.inv_5 == m3i_pkg::SatNeg ||
        res.data.inv_6 == m3i_pkg::SatPos || res.data.inv_6 == m3i_pkg::SatNeg ||
        res.data.inv_7 == m3i_pkg::SatPos || res.data.inv_7 == m3i_pkg::SatNeg ||
        res.data.inv_8 == m3i_pkg::SatPos || res.data.inv_8 == m3i_pkg::SatNeg;

    assign all_zero =
        res.data.inv_0 == '0 && res.data.inv_1 == '0 && res.data.inv_2 == '0 &&
        res.data.inv_3 == '0 && res.data.inv_4 == '0 && res.data.inv_5 == '0 &&
        res.data.inv_6 == '0 && res.data.inv_7 == '0 && res.data.inv_8 == '0;

    // A stalled result keeps its valid and its payload.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |=> res.valid && $stable(res.data))
        else $error("result changed while stalled");

    // A singular matrix gives all-zero elements and no overflow.
    a_singular: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.data.singular |-> all_zero && !res.data.overflow)
        else $error("singular result is not all zero");

    // Overflow is only reported when some element sits at a saturation limit.
    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.data.overflow |-> any_sat)
        else $error("overflow without a saturated element");

endmodule

bind matrix3_inverse m3i_checker u_m3i_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .res   (out_res)
);

>>> tb/tb_matrix3_inverse.sv
// Testbench for matrix3_inverse: directed and random 3x3 matrices checked against
// an exact fixed-point adjugate predictor held in a small scoreboard class.
// Depends on m3i_pkg, m3i_stream_if and the matrix3_inverse RTL.
`timescale 1ns / 1ps

module tb;

    class inverse_scoreboard;
        m3i_pkg::res_t pending[$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        // Exact inverse: Q32.32 cofactors, wide determinant, rounded quotient.
        function m3i_pkg::res_t compute_inverse(m3i_pkg::mat_t mt);
            logic signed [63:0]  m[9];
            logic signed [65:0]  c[9];
            logic signed [65:0]  adj[9];
            logic signed [131:0] det;
            logic [131:0]        magd;
            logic [131:0]        num;
            logic [131:0]        q;
            logic [31:0]         r[9];
            logic                negd;
            logic                neg;
            logic                ovf;
            logic [65:0]         ma;
            m3i_pkg::res_t       res;
            m[0] = mt.elem_0; m[1] = mt.elem_1; m[2] = mt.elem_2;
            m[3] = mt.elem_3; m[4] = mt.elem_4; m[5] = mt.elem_5;
            m[6] = mt.elem_6; m[7] = mt.elem_7; m[8] = mt.elem_8;
            c[0] = m[4] * m[8] - m[5] * m[7];
            c[1] = m[5] * m[6] - m[3] * m[8];
            c[2] = m[3] * m[7] - m[4] * m[6];
            c[3] = m[2] * m[7] - m[1] * m[8];
            c[4] = m[0] * m[8] - m[2] * m[6];
            c[5] = m[1] * m[6] - m[0] * m[7];
            c[6] = m[1] * m[5] - m[2] * m[4];
            c[7] = m[2] * m[3] - m[0] * m[5];
            c[8] = m[0] * m[4] - m[1] * m[3];
            det = 132'(m[0]) * 132'(c[0]) + 132'(m[1]) * 132'(c[1])
                + 132'(m[2]) * 132'(c[2]);
            res = '0;
            if (det == 0)
            begin
                res.singular = 1'b1;
                return res;
            end
            negd = det < 0;
            magd = negd ? -det : det;
            adj[0] = c[0]; adj[1] = c[3]; adj[2] = c[6];
            adj[3] = c[1]; adj[4] = c[4]; adj[5] = c[7];
            adj[6] = c[2]; adj[7] = c[5]; adj[8] = c[8];
            ovf = 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                ma = adj[i] < 0 ? -adj[i] : adj[i];
                neg = (adj[i] < 0) != negd;
                // Round half away from zero: (2*|a|*2^32 + |d|) / (2*|d|).
                num = (132'(ma) << 33) + magd;
                q = num / (magd << 1);
                if (q > (neg ? 132'h80000000 : 132'h7FFFFFFF))
                begin
                    r[i] = neg ? m3i_pkg::SatNeg : m3i_pkg::SatPos;
                    ovf = 1'b1;
                end
                else
                    r[i] = neg ? -q[31:0] : q[31:0];
            end
            res.inv_0 = r[0]; res.inv_1 = r[1]; res.inv_2 = r[2];
            res.inv_3 = r[3]; res.inv_4 = r[4]; res.inv_5 = r[5];
            res.inv_6 = r[6]; res.inv_7 = r[7]; res.inv_8 = r[8];
            res.overflow = ovf;
            return res;
        endfunction

        function void note_request(m3i_pkg::mat_t mt);
            pending.push_back(compute_inverse(mt));
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
            errors++;
        endtask

        task check_result(m3i_pkg::res_t got);
            m3i_pkg::res_t want;
            if (pending.size() == 0)
            begin
                report("unexpected result", 0, 0);
                return;
            end
            want = pending.pop_front();
            if (got.inv_0 !== want.inv_0) report("inv_0", got.inv_0, want.inv_0);
            if (got.inv_1 !== want.inv_1) report("inv_1", got.inv_1, want.inv_1);
            if (got.inv_2 !== want.inv_2) report("inv_2", got.inv_2, want.inv_2);
            if (got.inv_3 !== want.inv_3) report("inv_3", got.inv_3, want.inv_3);
            if (got.inv_4 !== want.inv_4) report("inv_4", got.inv_4, want.inv_4);
            if (got.inv_5 !== want.inv_5) report("inv_5", got.inv_5, want.inv_5);
            if (got.inv_6 !== want.inv_6) report("inv_6", got.inv_6, want.inv_6);
            if (got.inv_7 !== want.inv_7) report("inv_7", got.inv_7, want.inv_7);
            if (got.inv_8 !== want.inv_8) report("inv_8", got.inv_8, want.inv_8);
            if (got.singular !== want.singular)
                report("singular", got.singular, want.singular);
            if (got.overflow !== want.overflow)
                report("overflow", got.overflow, want.overflow);
        endtask
    endclass

    localparam int Latency = 41;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic long_stall = 1'b0;
    int   stall_pct = 30;

    m3i_stream_if #(.payload_t(m3i_pkg::mat_t)) in_req ();
    m3i_stream_if #(.payload_t(m3i_pkg::res_t)) out_res ();

    inverse_scoreboard board = new();

    matrix3_inverse u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_req  (in_req.sink),
        .out_res (out_res.source)
    );

    always #5 clk = ~clk;

    initial
    begin
        in_req.valid = 1'b0;
        in_req.data = '0;
        out_res.ready = 1'b0;
    end

    // Receiver stall pattern, with a long hold-off when requested.
    always @(negedge clk)
    begin
        if (long_stall)
            out_res.ready <= 1'b0;
        else
            out_res.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && in_req.valid && in_req.ready)
            board.note_request(in_req.data);
        if (rst_n && out_res.valid && out_res.ready)
            board.check_result(out_res.data);
    end

    function logic [31:0] pick_elem();
        case ($urandom_range(9))
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return 32'h0;
            3: return 32'h00010000 * $urandom_range(4);
            4: return 32'(-32'sh00010000 * $urandom_range(4));
            5: return 32'($signed($urandom_range(32'h3FFFF)) - 32'sh1FFFF);
            6: return 32'($urandom_range(3));
            default: return $urandom();
        endcase
    endfunction

    function m3i_pkg::mat_t random_matrix();
        m3i_pkg::mat_t mt;
        logic [31:0] e[9];
        for (int i = 0; i < 9; i++)
            e[i] = pick_elem();
        // Sometimes force dependent rows so singular matrices show up.
        if ($urandom_range(7) == 0)
            begin
                e[6] = e[0]; e[7] = e[1]; e[8] = e[2];
            end
        mt = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
        return mt;
    endfunction

    task send(m3i_pkg::mat_t mt);
        in_req.valid <= 1'b1;
        in_req.data <= mt;
        @(posedge clk);
        while (!in_req.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task pause(int n);
        in_req.valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task drain();
        in_req.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
    endtask

    m3i_pkg::mat_t directed[$];

    initial
    begin
        int burst;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed.push_back({32'h10000, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h0,
                            32'h0, 32'h0, 32'h10000});
        directed.push_back({32'h20000, 32'h0, 32'h0, 32'h0, 32'h30000, 32'h0,
                            32'h0, 32'h0, 32'hFFFC0000});
        directed.push_back('0);
        directed.push_back({9{32'h10000}});
        directed.push_back({9{32'h7FFFFFFF}});
        directed.push_back({9{32'h80000000}});
        directed.push_back({32'h1, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h1});
        directed.push_back({32'h7FFFFFFF, 32'h0, 32'h0, 32'h0, 32'h7FFFFFFF, 32'h0,
                            32'h0, 32'h0, 32'h7FFFFFFF});
        directed.push_back({32'h80000000, 32'h0, 32'h0, 32'h0, 32'h80000000, 32'h0,
                            32'h0, 32'h0, 32'h80000000});
        directed.push_back({32'h80000000, 32'h7FFFFFFF, 32'h1, 32'hFFFFFFFF, 32'h80000000,
                            32'h7FFFFFFF, 32'h0, 32'h1, 32'h80000000});
        directed.push_back({32'h30000, 32'h0, 32'h0, 32'h0, 32'h30000, 32'h0,
                            32'h0, 32'h0, 32'h30000});
        directed.push_back({32'hFFFFFFFF, 32'h1, 32'h0, 32'h0, 32'hFFFFFFFF, 32'h1,
                            32'h1, 32'h0, 32'hFFFFFFFF});
        directed.push_back({32'hAAAAAAAA, 32'h55555555, 32'h12345678, 32'hFFFF0000,
                            32'h0000FFFF, 32'hDEADBEEF, 32'h80000001, 32'h7FFFFFFE,
                            32'h00010001});
        foreach (directed[i])
            send(directed[i]);
        drain();

        for (int n = 0; n < 900; )
        begin
            if (n == 300)
            begin
                // Hold the receiver off while the sender keeps pushing.
                long_stall = 1'b1;
                fork
                    begin
                        repeat (200) @(negedge clk);
                        long_stall = 1'b0;
                    end
                join_none
            end
            if (n == 600)
                drain();
            if (n == 700)
                stall_pct = 0;
            if (n == 800)
                stall_pct = 60;
            burst = $urandom_range(1, 40);
            // A burst ends at every hundredth request so the phase changes above are seen.
            for (int k = 0; k < burst && n < 900 && (k == 0 || n % 100 != 0); k++, n++)
                send(random_matrix());
            if ($urandom_range(3) != 0)
                pause($urandom_range(1, 12));
        end
        drain();
        repeat (Latency + 10) @(negedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("simulation failed");
        $finish;
    end
endmodule
